// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every clock edge
`define SFA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// overlapping implication
`define SFA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// widths, codes, start table and divider interface types of the fade block
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int FRAME_W   = 16;
    localparam int LEN_W     = 15;
    localparam int ALPHA_W   = 8;
    localparam int TYPE_W    = 4;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int DELAY_W   = 3;

    // serial divider: one quotient bit per step
    localparam int DIV_STEPS  = ALPHA_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int NUMER_W    = LEN_W + ALPHA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TYPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RGB    = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_FADE_IN = 4'd1;
    localparam logic [TYPE_W-1:0] TYPE_SLOW    = 4'd6;
    localparam logic [TYPE_W-1:0] TYPE_HOLD    = 4'd7;

    localparam logic [DELAY_W-1:0] HOLD_TICKS = 3'd5;
    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;
    localparam logic [LEN_W-1:0]   LEN_RESET  = 15'd60;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] numer;
        logic [LEN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ALPHA_W-1:0] quotient;
    } div_rsp_t;

    // frame counter loaded by a start item
    function automatic logic [FRAME_W-1:0] table_frame(input logic [TYPE_W-1:0] kind);
        logic [FRAME_W-1:0] frame;
        case (kind)
            TYPE_FADE_IN: frame = 16'hFFFA;
            TYPE_SLOW:    frame = 16'hFFAB;
            default:      frame = '0;
        endcase
        return frame;
    endfunction

endpackage

// ----- src/sfa_divider.sv -----
// ----------------------------------------------------------------------------
// sfa_divider
// restoring divider for floor(255 * numer / denom), one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfa_divider
    import sfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [NUMER_W-1:0]    rem_reg, rem_next;
    logic [NUMER_W-2:0]    den_reg, den_next;
    logic [ALPHA_W-1:0]    q_reg, q_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic                  fit;
    logic [NUMER_W-1:0]    diff;

    // trial subtract of the shifted divisor
    assign fit  = rem_reg >= {1'b0, den_reg};
    assign diff = rem_reg - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // 255 * n as (n << 8) - n
            rem_next = {req.numer, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, req.numer};
            den_next = {req.denom, {(ALPHA_W-1){1'b0}}};
            q_next   = '0;
            cnt_next = STEP_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (fit)
            begin
                rem_next = diff;
            end
            q_next    = {q_reg[ALPHA_W-2:0], fit};
            den_next  = den_reg >> 1;
            cnt_next  = cnt_reg - STEP_CNT_W'(1);
            done_next = (cnt_reg == STEP_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    `SFA_ASSERT_IMP(a_start_when_free, req.start, cnt_reg == '0 && !done_reg,
        "divider started while a division is in flight")
    `SFA_ASSERT(a_cnt_range, cnt_reg <= STEP_CNT_W'(DIV_STEPS),
        "divider step count out of range")

endmodule

// ----- src/screen_fade_alpha_generator_unit.sv -----
// ----------------------------------------------------------------------------
// screen_fade_alpha_generator_unit
// full-screen fade overlay opacity generator with a bit-serial alpha divider
// ----------------------------------------------------------------------------
// One result item leaves for every input item. For a start item, a tick that
// only spends hold delay and a tick in hold type, the fade state is updated
// at acceptance and the result then waits in ST_SEND until the output
// register can be loaded. A tick that leaves the counter at or below zero
// also passes through ST_LOAD, where it is seen that no division is needed.
// For a tick that leaves the counter positive, the saturating add and clamp
// settle at acceptance, ST_LOAD starts the divider, ST_DIV waits while the
// serial divider forms the 8 bits of alpha (one quotient bit per cycle) and
// takes the quotient, and ST_SEND loads the output register. The next item
// is taken once the current one has been handed to the output register,
// which may still hold an earlier result waiting for out_ready. Configuration
// writes are always taken (cfg_ready is tied high) and are expected only
// while no item is in flight.
`include "assert_macros.svh"

module screen_fade_alpha_generator_unit
    import sfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [FRAME_W-1:0]   step_rate,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ALPHA_W-1:0]   alpha,
    output logic                 finished,
    output logic                 draw_fill,
    output logic [RGB_W-1:0]     fill_color,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RGB_W-1:0]     cfg_data
);

    // control sequence
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_LOAD = 2'd1;  // counter settled, start divider
    localparam logic [1:0] ST_DIV  = 2'd2;  // quotient bits shifting in
    localparam logic [1:0] ST_SEND = 2'd3;  // hand result to output register

    logic [1:0]          state_reg, state_next;

    // configuration registers
    logic [LEN_W-1:0]    len_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [RGB_W-1:0]    rgb_reg;

    // fade state
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [ALPHA_W-1:0]  level_reg, level_next;
    logic                done_reg, done_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic                finished_reg;
    logic                draw_reg;
    logic [RGB_W-1:0]    color_reg;
    logic                out_load;

    // arithmetic
    logic                in_take;
    logic                fade_in;
    logic [FRAME_W:0]    sum_wide;
    logic [FRAME_W-1:0]  sum_sat;
    logic                at_end;
    logic                frame_pos;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign fade_in   = (type_reg == TYPE_FADE_IN);

    // signed add with saturation to 16 bits
    assign sum_wide = {frame_reg[FRAME_W-1], frame_reg} + {step_rate[FRAME_W-1], step_rate};
    always_comb
    begin
        if (sum_wide[FRAME_W] != sum_wide[FRAME_W-1])
        begin
            sum_sat = sum_wide[FRAME_W] ? {1'b1, {(FRAME_W-1){1'b0}}}
                                        : {1'b0, {(FRAME_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[FRAME_W-1:0];
        end
    end

    // counter reached the fade length
    assign at_end    = $signed(sum_sat) >= $signed({1'b0, len_reg});
    // only a positive counter needs a division, otherwise the quotient is zero
    assign frame_pos = !frame_reg[FRAME_W-1] && (frame_reg != '0);

    assign div_req.start = (state_reg == ST_LOAD) && frame_pos;
    assign div_req.numer = frame_reg[LEN_W-1:0];
    assign div_req.denom = len_reg;

    sfa_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register frees up as soon as its item is taken
    assign out_load = (state_reg == ST_SEND) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        frame_next = frame_reg;
        delay_next = delay_reg;
        level_next = level_reg;
        done_next  = done_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (opcode == OP_START)
                    begin
                        // start from the per-type table
                        frame_next = table_frame(type_reg);
                        level_next = fade_in ? FULL_ALPHA : '0;
                        done_next  = 1'b0;
                        if (fade_in)
                        begin
                            delay_next = HOLD_TICKS;
                        end
                        state_next = ST_SEND;
                    end
                    else if (delay_reg != '0)
                    begin
                        // spend one tick of hold delay
                        delay_next = delay_reg - DELAY_W'(1);
                        state_next = ST_SEND;
                    end
                    else if (type_reg == TYPE_HOLD)
                    begin
                        state_next = ST_SEND;
                    end
                    else
                    begin
                        if (at_end)
                        begin
                            frame_next = {1'b0, len_reg};
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            frame_next = sum_sat;
                        end
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (frame_pos)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    // zero quotient, also covers a zero fade length
                    level_next = fade_in ? FULL_ALPHA : '0;
                    state_next = ST_SEND;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    level_next = fade_in ? ~div_rsp.quotient : div_rsp.quotient;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '0;
            delay_reg     <= '0;
            level_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= LEN_RESET;
            type_reg      <= '0;
            rgb_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            delay_reg     <= delay_next;
            level_reg     <= level_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FADE_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                    CFG_FADE_TYPE:   type_reg <= cfg_data[TYPE_W-1:0];
                    CFG_FILL_RGB:    rgb_reg  <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            alpha_reg    <= level_reg;
            finished_reg <= done_reg;
            draw_reg     <= (level_reg != '0);
            color_reg    <= rgb_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign alpha      = alpha_reg;
    assign finished   = finished_reg;
    assign draw_fill  = draw_reg;
    assign fill_color = color_reg;

    `SFA_ASSERT_IMP(a_idle_div_free, in_ready, !div_rsp.busy && !div_rsp.done,
        "divider active while the block takes an item")
    `SFA_ASSERT_IMP(a_div_only_in_div, div_rsp.busy || div_rsp.done, state_reg == ST_DIV,
        "divider active outside the division step")
    `SFA_ASSERT_IMP(a_draw_matches, out_valid_reg, draw_reg == (alpha_reg != '0),
        "fill flag disagrees with alpha")

endmodule
